// ----- src/bpm_pkg.sv -----
package bpm_pkg;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int TICK_W   = 16;
    localparam int GAIN_W   = 24;
    localparam int MV16_W   = 16;
    localparam int COUNT_W  = 4;
    localparam int SPAN_W   = 32;
    localparam int PCT_W    = 7;
    localparam int MV_W     = 20;
    localparam int PROD_W   = GAIN_W + GAIN_W;

    // Widths of the divider numerator, divisor and quotient.
    localparam int NUM_W = 27;
    localparam int DEN_W = 20;
    localparam int QUO_W = 16;

    // Division by 100 as a reciprocal multiply. The shifted product is exact for
    // every capacity times percent product up to 65535 * 100.
    localparam int                RECIP_SHIFT = 30;
    localparam logic [GAIN_W-1:0] RECIP_100   = 24'd10737419;

    // Configuration port.
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COUNT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPAN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAP    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ADC_ON = 3'd6;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd52821;
    localparam logic [MV16_W-1:0]  MIN_RST   = 16'd3000;
    localparam logic [MV16_W-1:0]  MAX_RST   = 16'd4200;
    localparam logic [COUNT_W-1:0] COUNT_RST = 4'd1;
    localparam logic [SPAN_W-1:0]  SPAN_RST  = 32'd1000;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam int MAX_CELLS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ACC,
        ST_CHECK,
        ST_LO,
        ST_HI,
        ST_PCT,
        ST_PDIV,
        ST_PWAIT,
        ST_DIR,
        ST_RDIV,
        ST_RWAIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- src/bpm_if.sv -----
interface bpm_in_if import bpm_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] raw_sample;
    logic                frame_last;
    logic [TICK_W-1:0]   elapsed_ticks;

    modport source (output valid, output raw_sample, output frame_last,
                    output elapsed_ticks, input ready);
    modport sink   (input valid, input raw_sample, input frame_last,
                    input elapsed_ticks, output ready);
endinterface

interface bpm_out_if import bpm_pkg::*;;
    logic              valid;
    logic              ready;
    logic              success;
    logic [MV16_W-1:0] pack_mv;
    logic [PCT_W-1:0]  charge_percent;
    logic              is_charging;
    logic              in_range;
    logic [MV16_W-1:0] remaining_mah;

    modport source (output valid, output success, output pack_mv,
                    output charge_percent, output is_charging,
                    output in_range, output remaining_mah, input ready);
    modport sink   (input valid, input success, input pack_mv,
                    input charge_percent, input is_charging,
                    input in_range, input remaining_mah, output ready);
endinterface

// ----- src/bpm_div.sv -----
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits.
module bpm_div import bpm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {r_rem[DEN_W-1:0], r_quo[QUO_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= (DEN_W + 1)'(i_req.num[NUM_W-1:QUO_W]);
            r_quo <= i_req.num[QUO_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ----- src/battery_pack_monitor.sv -----
// A sample that does not end a frame holds ready low while it is scaled and accumulated,
// so such samples are never taken back to back. A frame-closing sample has its result
// valid after the bounds, percent, direction and remaining-capacity steps, mostly the
// bit-serial percent division (skipped when not needed); a result still waiting in the
// output register adds its stall. Throughput: one sample at a time. Reset (i_rst_n,
// synchronous, active low) loads register defaults, clears control, frame and monitor state.
module battery_pack_monitor import bpm_pkg::*; #(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpm_in_if.sink            i_smp,
    bpm_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Only the low SAMPLE_BITS of a conversion take part in the scaling.
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);
    localparam logic [COUNT_W-1:0] MAX_CELLS_C = COUNT_W'(MAX_CELLS);

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase;
    // pready is tied high so there are never wait states.
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  r_gain;
    logic [MV16_W-1:0]  r_min;
    logic [MV16_W-1:0]  r_max;
    logic [COUNT_W-1:0] r_count;
    logic [SPAN_W-1:0]  r_span;
    logic [MV16_W-1:0]  r_cap;
    logic               r_adc_on;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_min    <= MIN_RST;
            r_max    <= MAX_RST;
            r_count  <= COUNT_RST;
            r_span   <= SPAN_RST;
            r_cap    <= '0;
            r_adc_on <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GAIN:   r_gain   <= pwdata[GAIN_W-1:0];
                REG_MIN:    r_min    <= pwdata[MV16_W-1:0];
                REG_MAX:    r_max    <= pwdata[MV16_W-1:0];
                REG_COUNT:  r_count  <= pwdata[COUNT_W-1:0];
                REG_SPAN:   r_span   <= pwdata[SPAN_W-1:0];
                REG_CAP:    r_cap    <= pwdata[MV16_W-1:0];
                REG_ADC_ON: r_adc_on <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GAIN:   prdata = APB_DW'(r_gain);
            REG_MIN:    prdata = APB_DW'(r_min);
            REG_MAX:    prdata = APB_DW'(r_max);
            REG_COUNT:  prdata = APB_DW'(r_count);
            REG_SPAN:   prdata = APB_DW'(r_span);
            REG_CAP:    prdata = APB_DW'(r_cap);
            REG_ADC_ON: prdata = APB_DW'(r_adc_on);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath state.
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    // Latched input word.
    logic [SAMPLE_W-1:0] r_raw;
    logic                r_last;
    logic [TICK_W-1:0]   r_ticks;

    // Frame accumulators.
    logic [MV_W-1:0]    r_sum;
    logic [MV_W-1:0]    r_first;
    logic [COUNT_W-1:0] r_tally;

    // Held monitor state.
    logic [MV16_W-1:0] r_pack;
    logic [MV16_W-1:0] r_prev;
    logic [SPAN_W-1:0] r_acc;
    logic              r_chg;
    logic [PCT_W-1:0]  r_pct;

    // Per-frame working registers.
    logic              r_ok;
    logic [MV_W-1:0]   r_lo;
    logic [MV_W-1:0]   r_hi;
    logic [PROD_W-1:0] r_prod;

    // Output register.
    logic              r_ov;
    logic              r_o_success;
    logic [MV16_W-1:0] r_o_pack;
    logic [PCT_W-1:0]  r_o_pct;
    logic              r_o_chg;
    logic              r_o_range;
    logic [MV16_W-1:0] r_o_rem;

    // The one multiplier, shared by sample scaling, the pack bounds, the
    // percent numerator that goes to the divider, and the remaining capacity,
    // whose division by 100 is a multiply by a scaled reciprocal.
    logic [GAIN_W-1:0] mul_a;
    logic [GAIN_W-1:0] mul_b;

    t_div_req div_req;
    t_div_rsp div_rsp;

    bpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Scaled sample, saturated at 20 bits, and the saturated running sum.
    logic [MV_W-1:0] scaled_mv;
    logic [MV_W:0]   sum_wide;
    logic [MV_W-1:0] sum_sat;

    assign scaled_mv = (r_prod[PROD_W-1:MV_W+16] != '0) ? {MV_W{1'b1}}
                                                        : r_prod[MV_W+15:16];
    assign sum_wide  = {1'b0, r_sum} + {1'b0, scaled_mv};
    assign sum_sat   = sum_wide[MV_W] ? {MV_W{1'b1}} : sum_wide[MV_W-1:0];

    // Frame check. A full frame gives the sum; a lone sample from a pack of
    // several cells is taken as the whole pack voltage.
    logic            count_ok;
    logic            frame_full;
    logic            frame_single;
    logic            frame_ok;
    logic [MV_W-1:0] frame_mv;

    assign count_ok     = (r_count != '0) && (r_count <= MAX_CELLS_C);
    assign frame_full   = r_tally == r_count;
    assign frame_single = (r_count > COUNT_W'(1)) && (r_tally == COUNT_W'(1));
    assign frame_ok     = r_adc_on && count_ok && (frame_full || frame_single);
    assign frame_mv     = frame_full ? r_sum : r_first;

    // Percent decision against the pack bounds.
    logic [MV_W-1:0] pack_ext;
    logic            below_lo;
    logic            above_hi;
    logic            need_pdiv;

    assign pack_ext  = MV_W'(r_pack);
    assign below_lo  = pack_ext < r_lo;
    assign above_hi  = pack_ext > r_hi;
    assign need_pdiv = !below_lo && !above_hi && (r_hi != r_lo);

    // Direction decision: saturating tick sum, then compare with the span.
    logic [SPAN_W:0]   acc_wide;
    logic [SPAN_W-1:0] acc_sat;

    assign acc_wide = {1'b0, r_acc} + (SPAN_W + 1)'(r_ticks);
    assign acc_sat  = acc_wide[SPAN_W] ? {SPAN_W{1'b1}} : acc_wide[SPAN_W-1:0];

    logic out_free;
    assign out_free = !r_ov || o_res.ready;

    // Next state, multiplier operands and divider requests.
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        div_req = '{start: 1'b0, num: '0, den: '0};
        case (r_state)
            ST_IDLE: begin
                if (i_smp.valid) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                mul_a   = r_gain;
                mul_b   = GAIN_W'(r_raw & SAMPLE_MASK);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = r_last ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                mul_a   = GAIN_W'(r_min);
                mul_b   = GAIN_W'(r_count);
                n_state = ST_LO;
            end
            ST_LO: begin
                mul_a   = GAIN_W'(r_max);
                mul_b   = GAIN_W'(r_count);
                n_state = ST_HI;
            end
            ST_HI: begin
                n_state = ST_PCT;
            end
            ST_PCT: begin
                if (r_ok && need_pdiv) begin
                    mul_a   = GAIN_W'(pack_ext - r_lo);
                    mul_b   = GAIN_W'(PCT_FULL);
                    n_state = ST_PDIV;
                end else begin
                    n_state = ST_DIR;
                end
            end
            ST_PDIV: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod[NUM_W-1:0];
                div_req.den   = r_hi - r_lo;
                n_state       = ST_PWAIT;
            end
            ST_PWAIT: begin
                if (div_rsp.done) begin
                    n_state = ST_DIR;
                end
            end
            ST_DIR: begin
                mul_a   = GAIN_W'(r_cap);
                mul_b   = GAIN_W'(r_pct);
                n_state = ST_RDIV;
            end
            ST_RDIV: begin
                // Capacity times percent, times the reciprocal of 100.
                mul_a   = r_prod[GAIN_W-1:0];
                mul_b   = RECIP_100;
                n_state = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_smp.ready = r_state == ST_IDLE;

    always_ff @(posedge i_clk) begin
        // The remaining-capacity product is held while the result word waits.
        if (r_state != ST_RWAIT) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == ST_IDLE) begin
            r_raw   <= i_smp.raw_sample;
            r_last  <= i_smp.frame_last;
            r_ticks <= i_smp.elapsed_ticks;
        end
        if (r_state == ST_LO) begin
            r_lo <= r_prod[MV_W-1:0];
        end
        if (r_state == ST_HI) begin
            r_hi <= r_prod[MV_W-1:0];
        end
    end

    // Frame accumulators and held monitor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_first <= '0;
            r_tally <= '0;
            r_pack  <= '0;
            r_prev  <= '0;
            r_acc   <= '0;
            r_chg   <= 1'b0;
            r_pct   <= '0;
            r_ok    <= 1'b0;
        end else begin
            case (r_state)
                ST_ACC: begin
                    r_sum <= sum_sat;
                    if (r_tally == '0) begin
                        r_first <= scaled_mv;
                    end
                    if (r_tally != {COUNT_W{1'b1}}) begin
                        r_tally <= r_tally + 1'b1;
                    end
                end
                ST_CHECK: begin
                    r_ok <= frame_ok;
                    if (frame_ok) begin
                        r_pack <= (frame_mv[MV_W-1:MV16_W] != '0) ? {MV16_W{1'b1}}
                                                                  : frame_mv[MV16_W-1:0];
                    end
                    r_sum   <= '0;
                    r_first <= '0;
                    r_tally <= '0;
                end
                ST_PCT: begin
                    // Out-of-range voltages clamp; equal bounds count as full.
                    if (r_ok && below_lo) begin
                        r_pct <= '0;
                    end else if (r_ok && !need_pdiv) begin
                        r_pct <= PCT_FULL;
                    end
                end
                ST_PWAIT: begin
                    if (div_rsp.done) begin
                        r_pct <= div_rsp.quot[PCT_W-1:0];
                    end
                end
                ST_DIR: begin
                    if (r_ok) begin
                        if (acc_sat > r_span) begin
                            r_chg  <= r_pack > r_prev;
                            r_prev <= r_pack;
                            r_acc  <= '0;
                        end else begin
                            r_acc <= acc_sat;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: a finished result waits here until it is taken.
    logic load_out;
    assign load_out = (r_state == ST_RWAIT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_success <= r_ok;
            r_o_pack    <= r_pack;
            r_o_pct     <= r_pct;
            r_o_chg     <= r_chg;
            r_o_range   <= !below_lo && !above_hi;
            r_o_rem     <= r_prod[RECIP_SHIFT+MV16_W-1:RECIP_SHIFT];
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.success        = r_o_success;
    assign o_res.pack_mv        = r_o_pack;
    assign o_res.charge_percent = r_o_pct;
    assign o_res.is_charging    = r_o_chg;
    assign o_res.in_range       = r_o_range;
    assign o_res.remaining_mah  = r_o_rem;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result word appears only from the last step of the remaining capacity.
    a_out_from_rwait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == ST_RWAIT)
        else $error("result word raised outside the final step");

    // The frame accumulators are clear by the time a result is presented.
    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> r_tally == '0)
        else $error("frame tally not cleared when the result was loaded");

    // The divider is never restarted while it is still iterating.
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The percent on the output never leaves its clamped range.
    a_pct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.charge_percent <= PCT_FULL)
        else $error("charge percent above full scale");

endmodule

// ----- tb/bpm_result_checker.sv -----
module bpm_result_checker import bpm_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpm_in_if                 i_smp,
    bpm_out_if                i_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              success;
        logic [MV16_W-1:0] pack_mv;
        logic [PCT_W-1:0]  charge_percent;
        logic              is_charging;
        logic              in_range;
        logic [MV16_W-1:0] remaining_mah;
    } pack_report_t;

    // Register copies.
    logic [GAIN_W-1:0]  cfg_gain;
    logic [MV16_W-1:0]  cfg_min;
    logic [MV16_W-1:0]  cfg_max;
    logic [COUNT_W-1:0] cfg_count;
    logic [SPAN_W-1:0]  cfg_span;
    logic [MV16_W-1:0]  cfg_cap;
    logic               cfg_adc_on;

    // Frame accumulators and held pack state.
    logic [MV_W-1:0]    frame_sum;
    logic [MV_W-1:0]    frame_first;
    logic [COUNT_W-1:0] frame_tally;
    logic [MV16_W-1:0]  held_mv;
    logic [MV16_W-1:0]  last_decision_mv;
    logic [SPAN_W-1:0]  tick_acc;
    logic               charging;
    logic [PCT_W-1:0]   held_pct;

    pack_report_t pending_reports[$];
    int           fails   = 0;
    int           waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic logic [MV_W-1:0] scale_to_mv(logic [SAMPLE_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        prod = raw * cfg_gain;
        prod = prod >> 16;
        return (prod > PROD_W'(20'hFFFFF)) ? 20'hFFFFF : prod[MV_W-1:0];
    endfunction

    function automatic logic [PCT_W-1:0] soc_percent(logic [MV16_W-1:0] v);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] quot;
        lo = cfg_min * cfg_count;
        hi = cfg_max * cfg_count;
        if (v < lo) return '0;
        if (v > hi) return PCT_FULL;
        if (hi == lo) return PCT_FULL;
        quot = (64'(v - lo) * 64'(PCT_FULL)) / 64'(hi - lo);
        return quot[PCT_W-1:0];
    endfunction

    task automatic clear_all();
        cfg_gain         = GAIN_RST;
        cfg_min          = MIN_RST;
        cfg_max          = MAX_RST;
        cfg_count        = COUNT_RST;
        cfg_span         = SPAN_RST;
        cfg_cap          = '0;
        cfg_adc_on       = 1'b1;
        frame_sum        = '0;
        frame_first      = '0;
        frame_tally      = '0;
        held_mv          = '0;
        last_decision_mv = '0;
        tick_acc         = '0;
        charging         = 1'b0;
        held_pct         = '0;
        pending_reports.delete();
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [APB_DW-1:0] data);
        case (addr[ADDR_W-1:2])
            REG_GAIN:   cfg_gain   = data[GAIN_W-1:0];
            REG_MIN:    cfg_min    = data[MV16_W-1:0];
            REG_MAX:    cfg_max    = data[MV16_W-1:0];
            REG_COUNT:  cfg_count  = data[COUNT_W-1:0];
            REG_SPAN:   cfg_span   = data[SPAN_W-1:0];
            REG_CAP:    cfg_cap    = data[MV16_W-1:0];
            REG_ADC_ON: cfg_adc_on = data[0];
            default: ;
        endcase
    endtask

    task automatic absorb_sample(logic [SAMPLE_W-1:0] raw, logic last,
                                 logic [TICK_W-1:0] ticks);
        logic [MV_W-1:0] mv;
        logic [MV_W:0]   sum;
        logic [MV_W-1:0] v;
        logic            ok;
        logic [SPAN_W:0] acc;
        logic [31:0]     lo;
        logic [31:0]     hi;
        pack_report_t    rpt;
        mv  = scale_to_mv(raw);
        sum = frame_sum + mv;
        frame_sum = (sum > 21'hFFFFF) ? 20'hFFFFF : sum[MV_W-1:0];
        if (frame_tally == 0) frame_first = mv;
        if (frame_tally < 4'd15) frame_tally = frame_tally + 1'b1;
        if (!last) return;

        ok = 1'b0;
        v  = '0;
        if (cfg_adc_on && cfg_count >= 1 && cfg_count <= MAX_CELLS) begin
            if (frame_tally == cfg_count) begin
                v  = frame_sum;
                ok = 1'b1;
            end else if (cfg_count > 1 && frame_tally == 1) begin
                // A lone sample from a multi-cell pack is the whole pack voltage.
                v  = frame_first;
                ok = 1'b1;
            end
        end
        if (ok) begin
            held_mv  = (v > 20'hFFFF) ? 16'hFFFF : v[MV16_W-1:0];
            held_pct = soc_percent(held_mv);
            acc      = tick_acc + ticks;
            tick_acc = (acc > 33'hFFFFFFFF) ? '1 : acc[SPAN_W-1:0];
            if (tick_acc > cfg_span) begin
                charging         = (held_mv > last_decision_mv);
                last_decision_mv = held_mv;
                tick_acc         = '0;
            end
        end
        frame_sum   = '0;
        frame_first = '0;
        frame_tally = '0;

        lo = cfg_min * cfg_count;
        hi = cfg_max * cfg_count;
        rpt.success        = ok;
        rpt.pack_mv        = held_mv;
        rpt.charge_percent = held_pct;
        rpt.is_charging    = charging;
        rpt.in_range       = (held_mv >= lo && held_mv <= hi);
        rpt.remaining_mah  = MV16_W'((32'(cfg_cap) * 32'(held_pct)) / 32'(PCT_FULL));
        pending_reports.push_back(rpt);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        pack_report_t rpt;
        if (!i_rst_n) begin
            clear_all();
        end else begin
            if (psel && penable && pwrite && pready) write_reg(paddr, pwdata);
            if (i_smp.valid && i_smp.ready) begin
                absorb_sample(i_smp.raw_sample, i_smp.frame_last, i_smp.elapsed_ticks);
            end
            if (i_res.valid && i_res.ready) begin
                if (pending_reports.size() == 0) begin
                    fails++;
                    $display("%0t: result word arrived with none expected", $time);
                end else begin
                    rpt = pending_reports.pop_front();
                    check_field("success", rpt.success, i_res.success);
                    check_field("pack_mv", rpt.pack_mv, i_res.pack_mv);
                    check_field("charge_percent", rpt.charge_percent, i_res.charge_percent);
                    check_field("is_charging", rpt.is_charging, i_res.is_charging);
                    check_field("in_range", rpt.in_range, i_res.in_range);
                    check_field("remaining_mah", rpt.remaining_mah, i_res.remaining_mah);
                end
            end
        end
        waiting = pending_reports.size();
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top import bpm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch without any accepted word before the run is declared hung.
    // It is set well above what a frame-closing word, the settle pause and
    // random stalls can take, which leaves a wide margin.
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int PHASES          = 8;
    localparam int PHASE_WORDS     = 140;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bpm_in_if  smp ();
    bpm_out_if res ();

    int fail_count;
    int pending;

    // When set, both the sample sender and the result receiver stall at random.
    bit idle_on = 1'b1;

    // Shadow of the settings last written, used only to shape the stimulus.
    logic [GAIN_W-1:0]  cfg_gain  = GAIN_RST;
    logic [MV16_W-1:0]  cfg_min   = MIN_RST;
    logic [MV16_W-1:0]  cfg_max   = MAX_RST;
    logic [COUNT_W-1:0] cfg_count = COUNT_RST;

    battery_pack_monitor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpm_result_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (smp),
        .i_res        (res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver drops ready at random, with a probability of 12 percent, while idling is on.
    always @(posedge i_clk) begin
        res.ready <= !idle_on || ($urandom_range(0, 99) >= 12);
    end

    // Watchdog: any accepted word, on either channel or on the register port,
    // restarts the count of quiet cycles.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
                (psel && penable && pwrite && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    // One register write: a setup phase, then an access phase held until pready.
    // The bus then returns to idle so that back-to-back writes never raise
    // and lower psel in the same time step.
    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one sample word. Valid stays high after acceptance so that the next
    // word can follow without a gap; it is only lowered when a gap is taken.
    task automatic send_word(logic [SAMPLE_W-1:0] raw, logic last,
                             logic [TICK_W-1:0] ticks);
        while (idle_on && $urandom_range(0, 99) < 12) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid         <= 1'b1;
        smp.raw_sample    <= raw;
        smp.frame_last    <= last;
        smp.elapsed_ticks <= ticks;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    // Stops sending and waits until every expected result word has come back,
    // then lets extra cycles pass so that a sample that closes no frame has
    // certainly been absorbed. The first edge lets the checker record the last
    // accepted word before the count is read.
    task automatic hold_until_drained(int extra);
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Writes every register. The block is drained first so that it is idle.
    task automatic load_settings(logic [GAIN_W-1:0] gain, logic [MV16_W-1:0] min_mv,
                                 logic [MV16_W-1:0] max_mv, logic [COUNT_W-1:0] cells,
                                 logic [SPAN_W-1:0] span, logic [MV16_W-1:0] cap,
                                 logic adc_on);
        hold_until_drained(SETTLE_CYCLES);
        apb_write(REG_GAIN,   APB_DW'(gain));
        apb_write(REG_MIN,    APB_DW'(min_mv));
        apb_write(REG_MAX,    APB_DW'(max_mv));
        apb_write(REG_COUNT,  APB_DW'(cells));
        apb_write(REG_SPAN,   APB_DW'(span));
        apb_write(REG_CAP,    APB_DW'(cap));
        apb_write(REG_ADC_ON, APB_DW'(adc_on));
        cfg_gain  = gain;
        cfg_min   = min_mv;
        cfg_max   = max_mv;
        cfg_count = cells;
    endtask

    // Most raw samples are aimed at a per-cell voltage near the configured
    // window, some exactly on its edges, so the percent math is exercised in
    // depth; the rest are uniform over all 16 bits. The ceiling division makes
    // the scaled value land exactly on the target when the gain is at most 1.0.
    function automatic logic [SAMPLE_W-1:0] pick_raw();
        int unsigned     pick;
        int unsigned     lo_c;
        int unsigned     hi_c;
        int unsigned     target;
        longint unsigned raw;
        pick = $urandom_range(0, 9);
        if (pick < 3 || cfg_gain == 0) return SAMPLE_W'($urandom);
        lo_c = (cfg_min < cfg_max) ? cfg_min : cfg_max;
        hi_c = (cfg_min < cfg_max) ? cfg_max : cfg_min;
        if (pick == 9) begin
            target = $urandom_range(0, 1) ? lo_c : hi_c;
        end else begin
            target = $urandom_range((lo_c > 300) ? lo_c - 300 : 0, hi_c + 300);
        end
        raw = (longint'(target) * 65536 + cfg_gain - 1) / cfg_gain;
        return (raw > 65535) ? 16'hFFFF : SAMPLE_W'(raw);
    endfunction

    // One frame of random content. Most frames are well formed: as many words
    // as there are cells, or a single pack-voltage word. The rest are frames of
    // a wrong length (up to 17, past the point where the tally saturates) and
    // noise with the last-of-frame mark set at random.
    task automatic send_frame(inout int sent);
        int kind;
        int len;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            len = (cfg_count == 0) ? $urandom_range(1, MAX_CELLS_DEF) : cfg_count;
        end else if (kind < 77) begin
            len = 1;
        end else begin
            len = $urandom_range(1, 17);
        end
        for (k = 0; k < len; k++) begin
            send_word(pick_raw(), (kind >= 92) ? 1'($urandom) : (k == len - 1),
                      TICK_W'($urandom));
            sent++;
        end
    endtask

    initial begin
        logic [GAIN_W-1:0]  gain;
        logic [MV16_W-1:0]  min_mv;
        logic [MV16_W-1:0]  max_mv;
        logic [COUNT_W-1:0] cells;
        logic [SPAN_W-1:0]  span;
        logic [MV16_W-1:0]  cap;
        int                 phase;
        int                 sent;
        bit                 paused;

        // Every input of the block has a known value from time zero.
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        smp.valid         = 1'b0;
        smp.raw_sample    = '0;
        smp.frame_last    = 1'b0;
        smp.elapsed_ticks = '0;
        res.ready         = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first on the reset settings: an empty pack, a full
        // scale sample whose ticks force a direction decision, and a sample
        // inside the single-cell window (about 3600 mV at the reset gain).
        send_word(16'd0, 1'b1, 16'd0);
        send_word(16'hFFFF, 1'b1, 16'hFFFF);
        send_word(16'd4467, 1'b1, 16'd500);

        // Unity gain, three cells, a decision on every good frame, full capacity.
        // A full frame at half charge, a lone pack-voltage word at the top of
        // the window, and a frame that is one word short.
        load_settings(24'd65536, 16'd3000, 16'd4200, 4'd3, 32'd0, 16'hFFFF, 1'b1);
        send_word(16'd3000, 1'b0, 16'd0);
        send_word(16'd3600, 1'b0, 16'd0);
        send_word(16'd4200, 1'b1, 16'd1);
        send_word(16'd12600, 1'b1, 16'd7);
        send_word(16'd5000, 1'b0, 16'd0);
        send_word(16'd5000, 1'b1, 16'd9);

        // Largest gain: both the sample scaling and the pack voltage saturate.
        load_settings('1, 16'd0, 16'hFFFF, 4'd2, '1, 16'd0, 1'b1);
        send_word(16'hFFFF, 1'b0, 16'hFFFF);
        send_word(16'hFFFF, 1'b1, 16'hFFFF);

        // Equal bounds: a voltage right on them counts as full.
        load_settings(24'd65536, 16'd3000, 16'd3000, 4'd1, 32'd0, 16'd1000, 1'b1);
        send_word(16'd3000, 1'b1, 16'd1);
        send_word(16'd2999, 1'b1, 16'd1);
        send_word(16'd3001, 1'b1, 16'd1);

        // A cell count of zero, one above the supported maximum, and the ADC
        // interface switched off: every frame fails and carries the held values.
        load_settings(24'd65536, 16'd3000, 16'd4200, 4'd0, 32'd0, 16'd1000, 1'b1);
        send_word(16'd3500, 1'b1, 16'd1);
        load_settings(24'd65536, 16'd3000, 16'd4200, 4'(MAX_CELLS_DEF + 1), 32'd0,
                      16'd1000, 1'b1);
        send_word(16'd3500, 1'b1, 16'd1);
        load_settings(24'd65536, 16'd3000, 16'd4200, 4'd1, 32'd0, 16'd1000, 1'b0);
        send_word(16'd3500, 1'b1, 16'd1);

        // Zero gain and zero bounds on the widest pack.
        load_settings(24'd0, 16'd0, 16'd0, 4'(MAX_CELLS_DEF), 32'd5, 16'd77, 1'b1);
        for (int k = 0; k < MAX_CELLS_DEF; k++) begin
            send_word(16'($urandom), k == MAX_CELLS_DEF - 1, 16'($urandom));
        end

        // Random part, one phase per group of settings. The gain and the span
        // reach both their extremes in some phase; one phase runs with no idling
        // on either side, and in another the sender pauses until all
        // outstanding results are back.
        for (phase = 0; phase < PHASES; phase++) begin
            gain   = GAIN_RST;
            min_mv = MIN_RST;
            max_mv = MAX_RST;
            cells  = 4'($urandom_range(1, MAX_CELLS_DEF));
            span   = $urandom_range(0, 200000);
            cap    = 16'($urandom);
            case (phase)
                1: begin
                    // Unity gain with arbitrary bounds, minimum above maximum too.
                    gain   = 24'd65536;
                    min_mv = 16'($urandom);
                    max_mv = 16'($urandom);
                end
                2: begin
                    gain   = 24'($urandom);
                    min_mv = '0;
                    max_mv = '1;
                end
                3: span = '0;
                4: begin
                    gain  = '1;
                    cells = 4'(MAX_CELLS_DEF);
                    span  = '1;
                    cap   = '1;
                end
                5: begin
                    gain   = '0;
                    min_mv = '0;
                    max_mv = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
                end
                6: cells = 4'($urandom_range(0, 15));
                7: begin
                    cells = 4'd1;
                    span  = $urandom_range(0, 2000);
                end
                default: ;
            endcase
            load_settings(gain, min_mv, max_mv, cells, span, cap, 1'b1);
            idle_on = (phase != 3);
            sent    = 0;
            paused  = 1'b0;
            while (sent < PHASE_WORDS) begin
                send_frame(sent);
                if (phase == 2 && !paused && sent >= PHASE_WORDS / 2) begin
                    hold_until_drained(0);
                    paused = 1'b1;
                end
            end
        end

        hold_until_drained(SETTLE_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
